>>> rtl/aco_pkg.sv
// aco_pkg: shared types and constants for the ant tour step block
// no dependencies
package aco_pkg;
  localparam int NCITY = 256;
  localparam int NNB = 32;
  localparam int CW = 8;
  localparam int SW = 5;

  typedef enum logic [2:0] {
    MODE_COORD = 3'd0, MODE_PHER = 3'd1, MODE_NBR = 3'd2,
    MODE_START = 3'd3, MODE_STEP = 3'd4
  } mode_t;

  localparam logic CFG_NUM_CITIES = 1'b0;
  localparam logic CFG_START_CITY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_FETCH, S_WAIT, S_CALC, S_DIV, S_ACC,
    S_RFETCH, S_RWAIT, S_RCMP, S_FB, S_OUT
  } state_t;

  // divider control between sequencer and divider
  typedef struct packed {
    logic start;
    logic [63:0] dividend;
    logic [33:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic [63:0] quot;
  } div_rsp_t;
endpackage

>>> rtl/aco_candidate_list_tour_step.sv
// aco_candidate_list_tour_step: top level, sequencer and tables
// depends on aco_pkg, aco_ram, aco_div
//
// usage:
//  input channel (in_valid/in_ready) carries load, start and step transactions
//  output channel (out_valid/out_ready) carries one result per step transaction
//  load transactions may follow back to back
//  start clears the visited map
//  a step walks 32 neighbor slots; each usable slot at nonzero distance runs
//  the shared restoring divider, then a second roulette pass over up to 32
//  slots and, if it finds nothing, a fallback scan of up to 256 visited
//  bits, one bit a cycle
//  the divider loop sets the rate; one transaction is in work at a time
//  the result sits in an output register until taken; in_ready stays low
//  meanwhile
//  reset: visited map cleared by a clearing pass (in_ready low), current
//  city 0, steps 0, num_cities 256, start_city 0
//  tables are undefined until written
module aco_candidate_list_tour_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [7:0]  city_index,
  input  logic [7:0]  other_index,
  input  logic [4:0]  neighbor_slot,
  input  logic [15:0] coord_x,
  input  logic [15:0] coord_y,
  input  logic [31:0] pheromone_value,
  input  logic [15:0] random_fraction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  next_city,
  output logic        used_fallback,
  output logic        last_of_tour,
  output logic        tour_full,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);
  import aco_pkg::*;

  state_t state, state_next;
  logic [8:0] num_cities;
  logic [7:0] start_city;
  logic [NCITY-1:0] visited;
  logic [7:0] cur;
  logic [8:0] steps;
  logic [8:0] cnt;
  logic [5:0] slot;
  logic [15:0] rnd;
  logic [68:0] total, cum;
  logic [84:0] target;
  logic [63:0] w;
  logic [7:0] cand;
  logic [33:0] d2;
  logic acc_nz;
  // set by a start transaction: the clearing pass marks the current city
  logic mark_cur;

  logic [8:0] n_eff;
  assign n_eff = (num_cities > 9'(NCITY)) ? 9'(NCITY) : num_cities;

  logic acc;
  assign acc = in_valid && in_ready;

  // coordinate tables, read at the current city and the candidate
  logic [7:0]  cx_ra;
  logic [15:0] cx_rd, cy_rd;
  aco_ram #(.WIDTH(16), .DEPTH(NCITY)) u_cx (
    .clk, .we(acc && mode == MODE_COORD), .waddr(city_index), .wdata(coord_x),
    .raddr(cx_ra), .rdata(cx_rd));
  aco_ram #(.WIDTH(16), .DEPTH(NCITY)) u_cy (
    .clk, .we(acc && mode == MODE_COORD), .waddr(city_index), .wdata(coord_y),
    .raddr(cx_ra), .rdata(cy_rd));

  logic [31:0] ph_rd;
  aco_ram #(.WIDTH(32), .DEPTH(NCITY*NCITY)) u_ph (
    .clk, .we(acc && mode == MODE_PHER), .waddr({city_index, other_index}),
    .wdata(pheromone_value), .raddr({cur, cand}), .rdata(ph_rd));

  logic [7:0] nb_rd;
  aco_ram #(.WIDTH(8), .DEPTH(NCITY*NNB)) u_nb (
    .clk, .we(acc && mode == MODE_NBR), .waddr({city_index, neighbor_slot}),
    .wdata(other_index), .raddr({cur, slot[SW-1:0]}), .rdata(nb_rd));

  logic [63:0] wt_rd;
  logic wt_we;
  aco_ram #(.WIDTH(64), .DEPTH(NNB)) u_wt (
    .clk, .we(wt_we), .waddr(slot[SW-1:0]), .wdata(w),
    .raddr(slot[SW-1:0]), .rdata(wt_rd));

  div_req_t dreq;
  div_rsp_t drsp;
  aco_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  // coordinate fetch phases: sub 0 reads current, sub 1 reads candidate
  logic [1:0] sub;
  logic [15:0] curx, cury;
  assign cx_ra = (sub == 2'd0) ? cur : cand;

  logic [16:0] dx, dy;
  logic [15:0] adx, ady;
  assign dx = {1'b0, curx} - {1'b0, cx_rd};
  assign dy = {1'b0, cury} - {1'b0, cy_rd};
  assign adx = dx[16] ? 16'(-dx) : dx[15:0];
  assign ady = dy[16] ? 16'(-dy) : dy[15:0];

  // squares of the coordinate differences, full 32-bit products
  logic [31:0] sqx, sqy;
  assign sqx = {16'b0, adx} * {16'b0, adx};
  assign sqy = {16'b0, ady} * {16'b0, ady};

  logic usable;
  assign usable = (nb_rd != cur) && ({1'b0, nb_rd} < n_eff) && !visited[nb_rd];

  logic [84:0] scaled;
  assign scaled = {cum, 16'h0} + {5'b0, wt_rd, 16'h0};

  always_comb begin
    state_next = state;
    wt_we = 1'b0;
    dreq = '0;
    dreq.dividend = {ph_rd, 32'h0};
    dreq.divisor = d2;
    case (state)
      S_IDLE: if (acc) begin
        if (mode == MODE_START) state_next = S_CLR;
        else if (mode == MODE_STEP) begin
          if (steps + 9'd1 >= n_eff) state_next = S_OUT;
          else state_next = S_FETCH;
        end
      end
      S_CLR: if (cnt == 9'(NCITY-1)) state_next = S_IDLE;
      S_FETCH: state_next = S_WAIT;
      S_WAIT: state_next = S_CALC;
      S_CALC: begin
        if (sub == 2'd3) begin
          if (!usable) begin
            state_next = S_ACC;
          end else if (d2 == 0) begin
            state_next = S_ACC;
          end else begin
            dreq.start = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: if (!drsp.busy) state_next = S_ACC;
      S_ACC: begin
        // the slot weight is settled in w here
        wt_we = 1'b1;
        if (slot == 6'(NNB-1)) state_next = S_RFETCH;
        else state_next = S_FETCH;
      end
      S_RFETCH: state_next = S_RWAIT;
      S_RWAIT: state_next = S_RCMP;
      S_RCMP: begin
        if (!acc_nz) state_next = S_FB;
        else if (wt_rd != 0 && scaled >= target) state_next = S_OUT;
        else if (slot == 6'(NNB-1)) state_next = S_FB;
        else state_next = S_RFETCH;
      end
      S_FB: if (!visited[cnt[7:0]] || cnt + 9'd1 >= n_eff) state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt <= '0;
      num_cities <= 9'(NCITY);
      start_city <= '0;
      cur <= '0;
      steps <= '0;
      sub <= '0;
      mark_cur <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_CITIES) num_cities <= cfg_data;
        else start_city <= cfg_data[7:0];
      end
      case (state)
        S_IDLE: if (acc) begin
          cnt <= '0;
          slot <= '0;
          sub <= '0;
          total <= '0;
          cum <= '0;
          acc_nz <= 1'b0;
          rnd <= random_fraction;
          next_city <= '0;
          used_fallback <= 1'b0;
          last_of_tour <= 1'b0;
          mark_cur <= (mode == MODE_START);
          tour_full <= (mode == MODE_STEP) && (steps + 9'd1 >= n_eff);
          if (mode == MODE_START) begin
            cur <= ({1'b0, start_city} < n_eff) ? start_city : 8'd0;
            steps <= '0;
          end
        end
        S_CLR: begin
          // after a start the current city is left marked visited
          visited[cnt[7:0]] <= mark_cur && (cnt[7:0] == cur);
          cnt <= cnt + 9'd1;
        end
        S_FETCH: sub <= '0;
        S_WAIT: begin
          // coordinates of current city arrive, neighbor ready
          curx <= cx_rd;
          cury <= cy_rd;
          cand <= nb_rd;
          sub <= 2'd1;
        end
        S_CALC: begin
          if (sub == 2'd1) begin
            sub <= 2'd2;
          end else if (sub == 2'd2) begin
            d2 <= {2'b0, sqx} + {2'b0, sqy};
            sub <= 2'd3;
          end else if (sub == 2'd3) begin
            if (!usable) w <= '0;
            else w <= 64'hFFFF_FFFF_FFFF_FFFF;
            sub <= '0;
          end else begin
            sub <= 2'd1;
          end
        end
        S_DIV: if (!drsp.busy) w <= drsp.quot;
        S_ACC: begin
          total <= total + {5'b0, w};
          if (w != 0) acc_nz <= 1'b1;
          if (slot == 6'(NNB-1)) slot <= '0;
          else slot <= slot + 6'd1;
        end
        S_RFETCH: target <= {16'b0, total} * {69'b0, rnd};
        S_RCMP: begin
          if (wt_rd != 0) cum <= cum + {5'b0, wt_rd};
          if (acc_nz && wt_rd != 0 && scaled >= target) begin
            cur <= nb_rd;
            next_city <= nb_rd;
            visited[nb_rd] <= 1'b1;
            steps <= steps + 9'd1;
            last_of_tour <= (steps + 9'd2 == n_eff);
          end else if (slot != 6'(NNB-1)) begin
            slot <= slot + 6'd1;
          end
        end
        S_FB: begin
          if (!visited[cnt[7:0]] || cnt + 9'd1 >= n_eff) begin
            used_fallback <= 1'b1;
            steps <= steps + 9'd1;
            last_of_tour <= (steps + 9'd2 == n_eff);
            if (!visited[cnt[7:0]]) begin
              cur <= cnt[7:0];
              next_city <= cnt[7:0];
              visited[cnt[7:0]] <= 1'b1;
            end else begin
              cur <= '0;
              next_city <= '0;
              visited[0] <= 1'b1;
            end
          end else begin
            cnt <= cnt + 9'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // the divider only runs while the sequencer waits for it
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    drsp.busy |-> state == S_DIV) else $error("divider busy outside divide");
  // nothing is accepted while a result waits
  a_no_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during result");
  // a full tour result carries no city
  a_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tour_full) |-> (next_city == 0 && !used_fallback))
    else $error("tour full result not clean");
endmodule

>>> rtl/aco_ram.sv
// aco_ram: generic single-port-write, single-read ram with registered read
// no dependencies
module aco_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/aco_div.sv
// aco_div: radix-2 restoring divider, one quotient bit a cycle
// depends on aco_pkg
module aco_div (
  input  logic              clk,
  input  logic              rst,
  input  aco_pkg::div_req_t req,
  output aco_pkg::div_rsp_t rsp
);
  import aco_pkg::*;
  logic [63:0] q;
  logic [34:0] rem;
  logic [33:0] dv;
  logic [6:0]  cnt;
  logic [34:0] sh;
  logic [35:0] diff;

  assign sh = {rem[33:0], q[63]};
  assign diff = {1'b0, sh} - {2'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      q <= req.dividend;
      dv <= req.divisor;
      rem <= '0;
      cnt <= 7'd64;
    end else if (cnt != 0) begin
      if (!diff[35]) begin
        rem <= diff[34:0];
        q <= {q[62:0], 1'b1};
      end else begin
        rem <= sh;
        q <= {q[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
    end
  end
  assign rsp.busy = (cnt != 0);
  assign rsp.quot = q;
endmodule

>>> bench/tb_aco_candidate_list_tour_step.sv
// tb_aco_candidate_list_tour_step: self-checking bench for the ant tour step block
// depends on aco_pkg and aco_candidate_list_tour_step (rtl)
// a scoreboard class predicts every step result; tasks drive the input channel
`timescale 1ns / 1ps

module tb_aco_candidate_list_tour_step;
  import aco_pkg::*;

  // one step result as the block reports it
  typedef struct packed {
    logic [7:0] next;
    logic       fb;
    logic       last;
    logic       full;
  } step_out_t;

  // tour predictor: own copy of tables, visited map, walk state and registers
  class tour_scoreboard;
    logic [15:0] cx [256];
    logic [15:0] cy [256];
    logic [31:0] pher [65536];
    logic [7:0]  nbr [8192];
    bit          coord_ok [256];
    bit          pher_ok [65536];
    bit          nbr_ok [8192];
    bit [255:0]  visited;
    int          cur;
    int          steps;
    int          num_cities;
    int          start_city;
    step_out_t   pending [$];

    function new();
      visited = '0;
      cur = 0;
      steps = 0;
      num_cities = 256;
      start_city = 0;
    endfunction

    function int cities();
      return (num_cities > 256) ? 256 : num_cities;
    endfunction

    function bit usable(int c);
      return (c != cur) && (c < cities()) && !visited[c];
    endfunction

    // pheromone over squared distance, saturated for coincident cities
    function logic [63:0] weigh(int a, int b);
      int          dx;
      int          dy;
      longint      d2;
      logic [63:0] num;
      logic [63:0] den;
      dx = int'(cx[a]) - int'(cx[b]);
      dy = int'(cy[a]) - int'(cy[b]);
      d2 = longint'(dx) * dx + longint'(dy) * dy;
      if (d2 == 0) return '1;
      num = {pher[a * 256 + b], 32'h0};
      den = d2;
      return num / den;
    endfunction

    function void configure(logic idx, int val);
      if (idx == CFG_NUM_CITIES) num_cities = val & 9'h1ff;
      else start_city = val & 8'hff;
    endfunction

    function void note_input(logic [2:0] md, int ci, int oi, int slot, logic [15:0] x,
                             logic [15:0] y, logic [31:0] p, logic [15:0] rnd);
      logic [63:0] w [32];
      logic [68:0] total;
      logic [68:0] cum;
      logic [84:0] target;
      step_out_t   res;
      bit          found;
      int          pick;
      int          n;
      n = cities();
      case (md)
        MODE_COORD: begin
          cx[ci] = x;
          cy[ci] = y;
          coord_ok[ci] = 1;
        end
        MODE_PHER: begin
          pher[ci * 256 + oi] = p;
          pher_ok[ci * 256 + oi] = 1;
        end
        MODE_NBR: begin
          nbr[ci * 32 + slot] = 8'(oi);
          nbr_ok[ci * 32 + slot] = 1;
        end
        MODE_START: begin
          visited = '0;
          cur = (start_city < n) ? start_city : 0;
          visited[cur] = 1;
          steps = 0;
        end
        MODE_STEP: begin
          res = '0;
          if (steps + 1 >= n) begin
            res.full = 1;
          end else begin
            total = '0;
            for (int a = 0; a < 32; a++) begin
              w[a] = usable(nbr[cur * 32 + a]) ? weigh(cur, nbr[cur * 32 + a]) : 64'd0;
              total += w[a];
            end
            found = 0;
            pick = 0;
            if (total != 0) begin
              // roulette: first slot whose scaled running sum reaches r * total
              target = 85'(total) * 85'(rnd);
              cum = '0;
              for (int a = 0; a < 32 && !found; a++) begin
                if (w[a] != 0) begin
                  cum += w[a];
                  if ({cum, 16'h0} >= target) begin
                    pick = nbr[cur * 32 + a];
                    found = 1;
                  end
                end
              end
            end
            if (!found) begin
              res.fb = 1;
              for (int a = 0; a < n; a++) begin
                if (!visited[a]) begin
                  pick = a;
                  break;
                end
              end
            end
            visited[pick] = 1;
            cur = pick;
            steps = (steps + 1) & 9'h1ff;
            res.next = 8'(pick);
            res.last = (steps + 1 == n);
          end
          pending.push_back(res);
        end
        default: ;
      endcase
    endfunction

    // empty string when the result matches the oldest expectation
    function string check_result(step_out_t got);
      step_out_t want;
      if (pending.size() == 0)
        return $sformatf("unexpected result next=%0d", got.next);
      want = pending.pop_front();
      if (got !== want)
        return $sformatf("next %0d/%0d fallback %0b/%0b last %0b/%0b full %0b/%0b",
                         got.next, want.next, got.fb, want.fb, got.last, want.last,
                         got.full, want.full);
      return "";
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  mode;
  logic [7:0]  city_index;
  logic [7:0]  other_index;
  logic [4:0]  neighbor_slot;
  logic [15:0] coord_x;
  logic [15:0] coord_y;
  logic [31:0] pheromone_value;
  logic [15:0] random_fraction;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  next_city;
  logic        used_fallback;
  logic        last_of_tour;
  logic        tour_full;
  logic        cfg_we;
  logic        cfg_index;
  logic [8:0]  cfg_data;

  tour_scoreboard tour_sb;
  int             mismatches;
  int             sent_items;
  int             cycles;
  bit             hold_request;

  localparam int CYCLE_LIMIT = 30_000_000;
  localparam int IDLE_WAIT = 700;  // a start clears 256 bits
  localparam int HOLD_CYCLES = 4000;

  aco_candidate_list_tour_step DUT (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // one input transaction; valid is only dropped when a gap is drawn
  task automatic send(logic [2:0] md, int ci, int oi, int slot, logic [15:0] x,
                      logic [15:0] y, logic [31:0] p, logic [15:0] rnd);
    int gap;
    gap = $urandom_range(8, 0);
    if ($urandom_range(3, 0) == 0) gap = 0;  // back to back stretches
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    city_index <= 8'(ci);
    other_index <= 8'(oi);
    neighbor_slot <= 5'(slot);
    coord_x <= x;
    coord_y <= y;
    pheromone_value <= p;
    random_fraction <= rnd;
    do @(posedge clk); while (!(in_valid && in_ready));
    tour_sb.note_input(md, ci, oi, slot, x, y, p, rnd);
    sent_items++;
  endtask

  // loads carry random junk in the fields they do not use
  task automatic load_coord(int ci);
    logic [15:0] x;
    logic [15:0] y;
    // a tight grid now and then gives coincident cities
    if ($urandom_range(5, 0) == 0) begin
      x = 16'($urandom_range(1, 0));
      y = 16'($urandom_range(1, 0));
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
    end
    send(MODE_COORD, ci, $urandom, $urandom, x, y, $urandom, $urandom);
  endtask

  task automatic load_pher(int ci, int oi);
    logic [31:0] p;
    case ($urandom_range(5, 0))
      0: p = 32'd0;
      1: p = 32'hffff_ffff;
      2: p = $urandom_range(255, 1);
      default: p = $urandom;
    endcase
    send(MODE_PHER, ci, oi, $urandom, $urandom, $urandom, p, $urandom);
  endtask

  task automatic load_nbr(int ci, int slot);
    int v;
    int n;
    n = tour_sb.cities();
    case ($urandom_range(7, 0))
      0: v = ci;  // empty slot
      1: v = $urandom_range(255, 0);
      default: v = $urandom_range(n - 1, 0);
    endcase
    send(MODE_NBR, ci, v, slot, $urandom, $urandom, $urandom, $urandom);
  endtask

  // fill whatever the next step would read so no unwritten entry is used
  task automatic prepare_step();
    int c;
    int cur;
    if (tour_sb.steps + 1 >= tour_sb.cities()) return;
    cur = tour_sb.cur;
    for (int s = 0; s < 32; s++)
      if (!tour_sb.nbr_ok[cur * 32 + s]) load_nbr(cur, s);
    for (int s = 0; s < 32; s++) begin
      c = tour_sb.nbr[cur * 32 + s];
      if (tour_sb.usable(c)) begin
        if (!tour_sb.coord_ok[cur]) load_coord(cur);
        if (!tour_sb.coord_ok[c]) load_coord(c);
        if (!tour_sb.pher_ok[cur * 256 + c]) load_pher(cur, c);
      end
    end
  endtask

  task automatic step_item(logic [15:0] rnd);
    prepare_step();
    send(MODE_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, rnd);
  endtask

  task automatic random_rnd(output logic [15:0] rnd);
    case ($urandom_range(5, 0))
      0: rnd = 16'h0000;
      1: rnd = 16'hffff;
      default: rnd = 16'($urandom);
    endcase
  endtask

  // registers change only once nothing is in flight
  task automatic write_reg(logic idx, int val);
    in_valid <= 1'b0;
    while (tour_sb.pending.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 9'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    tour_sb.configure(idx, val);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int        gap;
    string     msg;
    step_out_t got;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      gap = $urandom_range(8, 0);
      if ($urandom_range(3, 0) == 0) gap = 0;
      if (hold_request) begin
        hold_request = 0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      got = '{next_city, used_fallback, last_of_tour, tour_full};
      msg = tour_sb.check_result(got);
      if (msg != "") report(msg);
    end
  end

  initial begin
    int          n_tab [10] = '{3, 3, 256, 8, 16, 511, 5, 12, 256, 4};
    int          s_tab [10] = '{0, 2, 0, 5, 200, 255, 4, 0, 3, 1};
    int          nc;
    int          sc;
    int          budget;
    int          phase;
    int          pick;
    logic [15:0] rnd;
    tour_sb = new();
    mismatches = 0;
    sent_items = 0;
    cycles = 0;
    hold_request = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = '0;
    city_index = '0;
    other_index = '0;
    neighbor_slot = '0;
    coord_x = '0;
    coord_y = '0;
    pheromone_value = '0;
    random_fraction = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: undefined modes are ignored, a step before any start walks
    // the reset state with city 0 not yet visited
    send(3'd5, 0, 255, 31, 16'hffff, 16'hffff, 32'hffff_ffff, 16'hffff);
    send(3'd6, 255, 0, 0, 0, 0, 0, 0);
    send(3'd7, 0, 0, 0, 0, 0, 0, 0);
    step_item(16'h0000);
    step_item(16'hffff);

    // phases of register settings; the table covers the extremes, then random
    phase = 0;
    while (sent_items < 1500) begin
      if (phase < 10) begin
        nc = n_tab[phase];
        sc = s_tab[phase];
      end else begin
        nc = ($urandom_range(7, 0) == 0) ? $urandom_range(256, 3) : $urandom_range(24, 3);
        sc = $urandom_range(nc + 2, 0);
      end
      write_reg(CFG_NUM_CITIES, nc);
      write_reg(CFG_START_CITY, sc);
      if (phase == 6) hold_request = 1;  // block fills while the receiver sits still
      budget = sent_items + ((tour_sb.cities() > 64) ? 200 : 130);
      // now and then the old tour goes on under the new city count
      if ($urandom_range(7, 0) != 0)
        send(MODE_START, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom);
      while (sent_items < budget) begin
        pick = $urandom_range(39, 0);
        if (pick == 0) begin
          send(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom);
        end else if (pick < 4) begin
          load_coord($urandom_range(tour_sb.cities() - 1, 0));
        end else if (pick < 7) begin
          load_pher($urandom_range(tour_sb.cities() - 1, 0), $urandom_range(255, 0));
        end else if (pick < 9) begin
          load_nbr($urandom_range(255, 0), $urandom_range(31, 0));
        end else if (pick < 11) begin
          send(MODE_START, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom);
        end else begin
          random_rnd(rnd);
          step_item(rnd);
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (tour_sb.pending.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    if (mismatches == 0 && tour_sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
